// ----- src/clsr_pkg.sv -----
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared constants for the combined shuffled generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int unsigned ValW  = 31;
  localparam int unsigned MultW = 16;
  localparam int unsigned ProdW = ValW + MultW;

  localparam logic [1:0] REG_MULT_ONE = 2'd0;
  localparam logic [1:0] REG_MOD_ONE  = 2'd1;
  localparam logic [1:0] REG_MULT_TWO = 2'd2;
  localparam logic [1:0] REG_MOD_TWO  = 2'd3;

  localparam logic [ValW-1:0] GEN_TWO_RESET = 31'd123456789;
  localparam int unsigned     WarmupExtra   = 7;

  // command handed to the shared modulo / divide unit
  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] num;
    logic [ValW-1:0]  den;
  } div_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ProdW-1:0] quo;
    logic [ValW-1:0]  rem;
  } div_rsp_t;

endpackage

// ----- src/clsr_divider.sv -----
// ----------------------------------------------------------------------------
// clsr_divider
// Restoring divider, one quotient bit per cycle: quotient and remainder.
// ----------------------------------------------------------------------------
module clsr_divider (
  input  logic              clk,
  input  logic              rst,
  input  clsr_pkg::div_cmd_t cmd,
  output clsr_pkg::div_rsp_t rsp
);
  import clsr_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] quo;
  logic [ValW:0]    rem;
  logic [ValW-1:0]  den;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [ValW+1:0]  trial;
  logic [ValW+1:0]  diff;

  assign trial = {rem, quo[ProdW-1]};
  assign diff  = trial - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(ProdW);
        quo  <= cmd.num;
        den  <= cmd.den;
        rem  <= '0;
      end else if (busy) begin
        if (diff[ValW+1]) begin
          rem <= trial[ValW:0];
          quo <= {quo[ProdW-2:0], 1'b0};
        end else begin
          rem <= diff[ValW:0];
          quo <= {quo[ProdW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[ValW-1:0];

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.rem < den) else $error("remainder not reduced");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !$past(done)) else $error("busy right after done");
`endif

endmodule

// ----- src/combined_lcg_shuffle_rng.sv -----
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two combined multiplicative generators feeding a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// channel  dir  signals                     contents
// s_axis   in   tvalid tready tdata[31:0]   req_type, seed_value
// m_axis   out  tvalid tready tdata[31:0]   random_value
// cfg      in   cfg_we cfg_index cfg_data   register writes
// All reductions go through one shared bit-serial divider; a pass issues the
// command, shifts out the 47 quotient bits and then signals done. A draw takes
// three passes; a seed adds TABLE_SIZE+8 passes before its draw.
// The input is held off while an item is in work or its result waits.
// After reset the table is cleared, slot by slot, before s_axis opens.
module combined_lcg_shuffle_rng #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [0] req_type, [31:1] seed_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] random_value, [31] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import clsr_pkg::*;

  localparam int unsigned IdxW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned Steps = TABLE_SIZE + WarmupExtra + 1;
  localparam int unsigned StW   = $clog2(Steps + 1);

  // reciprocal of TABLE_SIZE, exact for every 31-bit dividend
  localparam int unsigned LgT       = $clog2(TABLE_SIZE);
  localparam int unsigned RecipSh   = ValW + LgT;
  localparam logic [63:0] RecipRaw  = ((64'd1 << RecipSh) + 64'(TABLE_SIZE) - 64'd1)
                                      / 64'(TABLE_SIZE);
  localparam logic [31:0] NdivRecip = RecipRaw[31:0];

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SEED = 4'd2,
                         S_SEEDW = 4'd3, S_G1 = 4'd4, S_G1W = 4'd5,
                         S_G2 = 4'd6, S_G2W = 4'd7, S_SL = 4'd8,
                         S_SLW = 4'd9, S_RD = 4'd10, S_OUT = 4'd11,
                         S_RD0 = 4'd12, S_DIF = 4'd13;

  logic [3:0]       state;
  logic [MultW-1:0] mult_one, mult_two;
  logic [ValW-1:0]  mod_one, mod_two, m1, m2;
  logic [ValW-1:0]  gen_one, gen_two, last_output, res;
  logic [StW-1:0]   step;
  logic [IdxW-1:0]  clr_idx, slot;
  logic [ValW-1:0]  shuffle_table [TABLE_SIZE];
  logic [ValW-1:0]  tab_q;
  logic [ValW-1:0]  ndiv;
  logic [62:0]      nprod;
  logic [32:0]      diff;
  div_cmd_t         cmd;
  div_rsp_t         rsp;

  assign m1    = (mod_one < 31'd2) ? 31'd2 : mod_one;
  assign m2    = (mod_two < 31'd2) ? 31'd2 : mod_two;
  assign nprod = 63'(m1 - 31'd1) * 63'(NdivRecip);

  always_ff @(posedge clk) begin
    ndiv <= 31'(nprod >> RecipSh) + 31'd1;
  end

  clsr_divider u_div (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  always_comb begin
    cmd.start = 1'b0;
    cmd.num   = ProdW'(gen_one) * ProdW'(mult_one);
    cmd.den   = m1;
    case (state)
      S_SEED, S_G1: cmd.start = 1'b1;
      S_G2: begin
        cmd.start = 1'b1;
        cmd.num   = ProdW'(gen_two) * ProdW'(mult_two);
        cmd.den   = m2;
      end
      S_SL: begin
        cmd.start = 1'b1;
        cmd.num   = ProdW'(last_output);
        cmd.den   = ndiv;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {1'b0, res};
  assign diff = {2'b00, tab_q} - {2'b00, gen_two};

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_one <= 16'd40014;
      mod_one  <= 31'd2147483563;
      mult_two <= 16'd40692;
      mod_two  <= 31'd2147483399;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULT_ONE: mult_one <= cfg_data[MultW-1:0];
        REG_MOD_ONE:  mod_one  <= cfg_data;
        REG_MULT_TWO: mult_two <= cfg_data[MultW-1:0];
        REG_MOD_TWO:  mod_two  <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) shuffle_table[clr_idx] <= '0;
    else if (state == S_SEEDW && rsp.done && step < StW'(TABLE_SIZE))
      shuffle_table[step[IdxW-1:0]] <= rsp.rem;
    else if (state == S_RD) shuffle_table[slot] <= gen_one;
    tab_q <= shuffle_table[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      gen_one     <= 31'd1;
      gen_two     <= GEN_TWO_RESET;
      last_output <= '0;
      step        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IdxW'(TABLE_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          if (!s_axis_tdata[0]) begin
            gen_one <= (s_axis_tdata[31:1] == '0) ? 31'd1 : s_axis_tdata[31:1];
            gen_two <= (s_axis_tdata[31:1] == '0) ? 31'd1 : s_axis_tdata[31:1];
            step    <= StW'(Steps - 1);
            state   <= S_SEED;
          end else state <= S_G1;
        end
        S_SEED: state <= S_SEEDW;
        S_SEEDW: if (rsp.done) begin
          gen_one <= rsp.rem;
          // the last warm-up step fills slot 0, which seeds the slot pick
          if (step == '0) begin
            last_output <= rsp.rem;
            state       <= S_RD0;
          end else begin
            step  <= step - 1'b1;
            state <= S_SEED;
          end
        end
        S_RD0: state <= S_G1;
        S_G1: state <= S_G1W;
        S_G1W: if (rsp.done) begin
          gen_one <= rsp.rem;
          state   <= S_G2;
        end
        S_G2: state <= S_G2W;
        S_G2W: if (rsp.done) begin
          gen_two <= rsp.rem;
          state   <= S_SL;
        end
        S_SL: state <= S_SLW;
        S_SLW: if (rsp.done) begin
          slot  <= (rsp.quo > ProdW'(TABLE_SIZE - 1)) ? IdxW'(TABLE_SIZE - 1)
                                                      : rsp.quo[IdxW-1:0];
          state <= S_RD;
        end
        S_RD: state <= S_DIF;
        S_DIF: begin
          res         <= diff[32] || diff == '0 ? 31'(diff + 33'(m1 - 31'd1))
                                                : diff[ValW-1:0];
          last_output <= diff[32] || diff == '0 ? 31'(diff + 33'(m1 - 31'd1))
                                                : diff[ValW-1:0];
          state       <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    rsp.busy |-> !s_axis_tready) else $error("ready while dividing");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(res))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready)) else $error("ready with result pending");
`endif

endmodule
